// ----- hw/rtl/aesctr_pkg.sv -----
// Shared types, S-box table and AES round functions for the counter-mode byte cipher.
package aesctr_pkg;

  localparam int unsigned BlockW    = 128;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NumBytes  = BlockW / ByteW;
  localparam int unsigned PosW      = $clog2(NumBytes);
  localparam int unsigned LastRound = 10;
  localparam int unsigned RndW      = $clog2(LastRound + 1);

  typedef struct packed {
    logic start;
    logic abort;
  } eng_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the current one.
  function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {sub_byte(w3[23:16]) ^ rc, sub_byte(w3[15:8]), sub_byte(w3[7:0]),
          sub_byte(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns. Byte 0 is the top byte.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      b[i] = sub_byte(s[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = b[i + 4*((c+i) & 3)];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/aesctr_core.sv -----
// Iterative AES-128 core: one round and one key expansion step per cycle.
module aesctr_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  aesctr_pkg::eng_req_t        req_i,
  input  logic [7:0]                  key_i,
  input  logic [7:0]                  ctr_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [aesctr_pkg::BlockW-1:0] block_o
);
  import aesctr_pkg::*;

  logic              busy_q, busy_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic [7:0]        rcon_q, rcon_d;
  logic [BlockW-1:0] st_q, st_d, rk_q, rk_d;
  logic [BlockW-1:0] rk_nx, st_nx;
  logic              last;

  assign last  = (rnd_q == RndW'(LastRound));
  assign rk_nx = key_expand(rk_q, rcon_q);
  assign st_nx = aes_round(st_q, last) ^ rk_nx;

  always_comb begin
    busy_d = busy_q;
    rnd_d  = rnd_q;
    rcon_d = rcon_q;
    st_d   = st_q;
    rk_d   = rk_q;
    if (req_i.abort) begin
      busy_d = 1'b0;
    end else if (req_i.start) begin
      busy_d = 1'b1;
      rnd_d  = RndW'(1);
      rcon_d = 8'h01;
      rk_d   = {{(BlockW-8){1'b0}}, key_i};
      st_d   = {{(BlockW-8){1'b0}}, key_i ^ ctr_i};
    end else if (busy_q) begin
      st_d   = st_nx;
      rk_d   = rk_nx;
      rcon_d = xtime(rcon_q);
      rnd_d  = rnd_q + RndW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rcon_q <= rcon_d;
    st_q   <= st_d;
    rk_q   <= rk_d;
  end

  assign busy_o  = busy_q;
  assign done_o  = busy_q & last;
  assign block_o = st_nx;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q || $past(req_i.start))
    else $error("core stayed busy after last round");
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rnd_q != '0) && (rnd_q <= RndW'(LastRound)))
    else $error("round count out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("start while busy");

endmodule

// ----- hw/rtl/aes128_ctr_byte_stream_cipher_unit.sv -----
// Top level of the AES-128 counter-mode byte stream cipher.
// Usage:
//   Input channel in_valid_i/in_ready_o carries one item: data_byte_i and
//   first_of_message_i. Output channel out_valid_o/out_ready_i returns one
//   cipher_byte_o per item, in order.
//   key_byte_we_i writes key_byte_i, the last key byte.
// The result is registered and visible in the cycle after acceptance.
// Throughput: one item per cycle while the output is not held and the needed
//   keystream block is ready. The keystream block for counter zero is cached,
//   and the block for the next counter is prepared by the iterative AES core
//   (load and ten rounds) while the current block is in use. A block boundary
//   reached before the core has finished the next block waits for it; a restart
//   waits only until the counter zero block exists.
// Reset: clears counter and position; the core then prepares the counter
//   zero block and the counter one block, so a first item of a message is
//   taken once the counter zero block exists and an unmarked one once the
//   counter one block exists. A key write discards both and repeats this.
// Stall: a held output keeps out_valid_o and cipher_byte_o; a new item can be
//   taken in the same cycle as the held one leaves.
module aes128_ctr_byte_stream_cipher_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       key_byte_we_i,
  input  logic [7:0] key_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cipher_byte_o
);
  import aesctr_pkg::*;

  logic [7:0]        key_q, ctr_q, ctr_d;
  logic [PosW-1:0]   pos_q, pos_d, pos_eff;
  logic [BlockW-1:0] ks_q, z_q, n_q, ks_use, eng_blk;
  logic              z_vld_q, z_vld_d, n_vld_q, n_vld_d, eng_z_q, eng_z_d;
  logic              ov_q;
  logic [7:0]        out_q;
  logic              need_new, blk_ok, acc, ctr_kill, store;
  logic              eng_busy, eng_done;
  eng_req_t          req;

  assign need_new = first_of_message_i | (pos_q == '0);
  assign blk_ok   = !need_new | (first_of_message_i ? z_vld_q : n_vld_q);
  assign in_ready_o = (!ov_q | out_ready_i) & blk_ok;
  assign acc      = in_valid_i & in_ready_o;
  assign ctr_kill = acc & need_new;
  assign pos_eff  = first_of_message_i ? '0 : pos_q;
  assign ks_use   = first_of_message_i ? z_q : ((pos_q == '0) ? n_q : ks_q);

  assign req.abort = key_byte_we_i | (ctr_kill & eng_busy & !eng_z_q);
  assign req.start = !eng_busy & !key_byte_we_i & !ctr_kill & (!z_vld_q | !n_vld_q);
  assign store     = eng_done & !key_byte_we_i & (eng_z_q | !ctr_kill);

  aesctr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .key_i   (key_q),
    .ctr_i   (z_vld_q ? ctr_q + 8'd1 : 8'd0),
    .busy_o  (eng_busy),
    .done_o  (eng_done),
    .block_o (eng_blk)
  );

  always_comb begin
    ctr_d   = ctr_q;
    pos_d   = pos_q;
    z_vld_d = z_vld_q;
    n_vld_d = n_vld_q;
    eng_z_d = eng_z_q;
    if (req.start) begin
      eng_z_d = !z_vld_q;
    end
    if (acc) begin
      pos_d = pos_eff + PosW'(1);
      priority if (first_of_message_i) begin
        ctr_d = '0;
      end else if (pos_q == '0) begin
        ctr_d = ctr_q + 8'd1;
      end
    end
    if (store && eng_z_q) begin
      z_vld_d = 1'b1;
    end
    if (store && !eng_z_q) begin
      n_vld_d = 1'b1;
    end
    if (ctr_kill) begin
      n_vld_d = 1'b0;
    end
    if (key_byte_we_i) begin
      z_vld_d = 1'b0;
      n_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      ctr_q   <= '0;
      pos_q   <= '0;
      z_vld_q <= 1'b0;
      n_vld_q <= 1'b0;
      eng_z_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (key_byte_we_i) begin
        key_q <= key_byte_i;
      end
      ctr_q   <= ctr_d;
      pos_q   <= pos_d;
      z_vld_q <= z_vld_d;
      n_vld_q <= n_vld_d;
      eng_z_q <= eng_z_d;
      if (acc) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store && eng_z_q) begin
      z_q <= eng_blk;
    end
    if (store && !eng_z_q) begin
      n_q <= eng_blk;
    end
    if (acc && need_new) begin
      ks_q <= ks_use;
    end
    if (acc) begin
      out_q <= data_byte_i ^ ks_use[BlockW-1-ByteW*pos_eff -: ByteW];
    end
  end

  assign out_valid_o   = ov_q;
  assign cipher_byte_o = out_q;

  a_first_has_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && first_of_message_i) |-> z_vld_q)
    else $error("restart accepted without counter zero block");
  a_bound_has_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !first_of_message_i && pos_q == '0) |-> n_vld_q)
    else $error("block boundary accepted without next block");
  a_key_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_byte_we_i |=> !z_vld_q && !n_vld_q)
    else $error("cached blocks survived a key write");
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!ov_q || out_ready_i))
    else $error("ready with full output register");

endmodule

// ----- bench/aes128_ctr_byte_stream_cipher_unit_tb.sv -----
// Self-checking bench for the AES-128 counter-mode byte cipher: scoreboard, predictor, stimulus.
class ctr_byte_scoreboard;
  logic [7:0] sbox_q [256];
  logic [7:0] key_q;
  logic [7:0] ctr_q;
  logic [3:0] pos_q;
  logic [7:0] ks_q [16];
  logic [7:0] rk_q [11][16];
  logic [7:0] cipher_q [$];
  int errors;
  int n_checked;

  function new();
    logic [7:0] p, q, x;
    p = 8'd1;
    q = 8'd1;
    sbox_q[0] = 8'h63;
    do begin
      p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
      q = q ^ {q[6:0], 1'b0};
      q = q ^ {q[5:0], 2'b0};
      q = q ^ {q[3:0], 4'b0};
      if (q[7]) q = q ^ 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
      sbox_q[p] = x ^ 8'h63;
    end while (p != 8'd1);
    errors = 0;
    n_checked = 0;
    reset_state();
  endfunction

  function logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function void set_key(input logic [7:0] k);
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] t0, rc;
    rc = 8'd1;
    key_q = k;
    for (int i = 0; i < 16; i++) w[i] = 8'h00;
    w[15] = k;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = w[i-4+j];
      if ((i % 16) == 0) begin
        t0 = t[0];
        t[0] = sbox_q[t[1]] ^ rc;
        t[1] = sbox_q[t[2]];
        t[2] = sbox_q[t[3]];
        t[3] = sbox_q[t0];
        rc = xt(rc);
      end
      for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ t[j];
    end
    for (int r = 0; r < 11; r++)
      for (int i = 0; i < 16; i++) rk_q[r][i] = w[r*16+i];
  endfunction

  function void reset_state();
    ctr_q = 8'd0;
    pos_q = 4'd0;
    set_key(8'h00);
  endfunction

  function void encrypt_counter();
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) s[i] = rk_q[0][i];
    s[15] = ctr_q ^ rk_q[0][15];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sbox_q[s[i]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i) & 3)];
      s = t;
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
          s[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
          s[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
          s[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk_q[r][i];
    end
    ks_q = s;
  endfunction

  function void note_plain(input logic [7:0] d, input logic first);
    if (first) begin
      ctr_q = 8'd0;
      pos_q = 4'd0;
      encrypt_counter();
    end else if (pos_q == 4'd0) begin
      ctr_q = ctr_q + 8'd1;
      encrypt_counter();
    end
    cipher_q.insert(cipher_q.size(), d ^ ks_q[pos_q]);
    pos_q = pos_q + 4'd1;
  endfunction

  function bit check_cipher(input logic [7:0] c, output logic [7:0] want);
    n_checked++;
    if (cipher_q.size() == 0) begin
      want = 'x;
      return 0;
    end
    want = cipher_q.pop_front();
    return c === want;
  endfunction
endclass

module aes128_ctr_byte_stream_cipher_unit_tb;
  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       key_byte_we_i = 0;
  logic [7:0] key_byte_i = 0;
  logic       in_valid_i = 0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 0;
  logic       first_of_message_i = 0;
  logic       out_valid_o;
  logic       out_ready_i = 0;
  logic [7:0] cipher_byte_o;

  ctr_byte_scoreboard sb = new();
  int mismatches = 0;
  int cycles = 0;
  int n_msgs = 0;
  bit sink_idle_ok = 1;

  aes128_ctr_byte_stream_cipher_unit dut (.*);

  always #2 clk_i = ~clk_i;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch: %s got %02h want %02h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("aes128_ctr_byte_stream_cipher_unit_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_plain(data_byte_i, first_of_message_i);
  end

  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sb.cipher_q.size() == 0) report("unexpected item", cipher_byte_o, 8'h00);
      else if (!sb.check_cipher(cipher_byte_o, want)) report("cipher_byte", cipher_byte_o, want);
    end
  end

  // receiver: random stalls, with stretches of none
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = sink_idle_ok && ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 7)) : 0;
      repeat (w) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  task automatic send(input logic [7:0] d, input logic first, input bit gaps);
    int w;
    w = gaps ? int'($urandom_range(0, 7)) : 0;
    if (w > 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= d;
    first_of_message_i <= first;
    if (first) n_msgs++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.cipher_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [7:0] k);
    drain();
    key_byte_we_i <= 1'b1;
    key_byte_i <= k;
    @(posedge clk_i);
    key_byte_we_i <= 1'b0;
    sb.set_key(k);
  endtask

  initial begin
    int len;
    bit gaps;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // continuation without a first mark after reset
    send(8'h00, 1'b0, 1'b0);
    send(8'hff, 1'b0, 1'b0);
    for (int i = 0; i < 18; i++) send(i[0] ? 8'hff : 8'h00, i == 0, 1'b0);
    write_key(8'hff);
    send(8'ha5, 1'b1, 1'b0);
    send(8'h5a, 1'b1, 1'b0);
    send(8'h3c, 1'b0, 1'b1);
    write_key(8'h80);
    // long message across many block boundaries
    send(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    for (int i = 0; i < 120; i++) send(8'($urandom_range(0, 255)), 1'b0, i < 40);
    for (int ph = 0; ph < 4; ph++) begin
      write_key(ph == 3 ? 8'h00 : 8'($urandom_range(0, 255)));
      for (int m = 0; m < 6; m++) begin
        len = int'($urandom_range(1, 30));
        gaps = $urandom_range(0, 2) != 0;
        for (int i = 0; i < len; i++)
          send(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 30) == 0, gaps);
      end
      if (ph == 1) begin
        sink_idle_ok = 0;
        drain();
        sink_idle_ok = 1;
      end
    end
    drain();
    repeat (30) @(posedge clk_i);
    $display("covered %0d results over %0d messages, key writes incl. 0x00/0xff/0x80,",
             sb.n_checked, n_msgs);
    $display("many block boundaries, restarts and random stalls on both channels");
    if (mismatches == 0 && sb.cipher_q.size() == 0) begin
      $display("aes128_ctr_byte_stream_cipher_unit_tb passed");
    end else begin
      $display("aes128_ctr_byte_stream_cipher_unit_tb failed");
    end
    $finish;
  end
endmodule
